>>> hw/rtl/cdc_pkg.sv
package cdc_pkg;

   localparam int YEAR_BITS = 16;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int FYEAR_W  = 16;
   localparam int COUNT_W  = 16;
   localparam int R400_W   = 9;
   localparam int ALU_W    = YEAR_BITS + MONTH_W + DAY_W;

   // A 16-bit year over 400 is below 164. The year over 16 is a 12-bit value, and
   // for those (x * 1311) >> 15 is exactly x / 25.
   localparam int QUO_W       = 8;
   localparam int RECIP_W     = 11;
   localparam int PROD_W      = FYEAR_W - 4 + RECIP_W;
   localparam int RECIP_SHIFT = 15;
   localparam logic [RECIP_W-1:0] RECIP_25 = RECIP_W'(1311);

   localparam logic [R400_W-1:0]    YEAR_PERIOD = R400_W'(400);
   localparam logic [YEAR_BITS-1:0] RESET_YEAR  = YEAR_BITS'(2000);
   localparam logic [R400_W-1:0]    RESET_R400  =
      R400_W'((2000 % (64'd1 << YEAR_BITS)) % 400);
   localparam logic [MONTH_W-1:0]   LAST_MONTH  = MONTH_W'(12);

   typedef logic [YEAR_BITS-1:0] year_type;

   typedef enum logic [1:0] {
      OP_SET     = 2'd0,
      OP_ADVANCE = 2'd1,
      OP_COMPARE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_MONTH = 2'd1,
      STAT_BAD_DAY   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SET_MOD,
      S_SET_REM,
      S_SET_CHK,
      S_ADVANCE,
      S_COMPARE,
      S_RESPOND
   } state_type;

   typedef struct packed {
      op_type               op;
      logic [DAY_W-1:0]     day_in;
      logic [MONTH_W-1:0]   month_in;
      logic [FYEAR_W-1:0]   year_in;
      logic [COUNT_W-1:0]   day_count;
   } req_type;

   typedef struct packed {
      logic [DAY_W-1:0]     day_out;
      logic [MONTH_W-1:0]   month_out;
      logic [FYEAR_W-1:0]   year_out;
      status_type           status;
      logic                 is_earlier;
   } rsp_type;

   typedef struct packed {
      logic                 borrow;
      logic [ALU_W-1:0]     diff;
   } alu_res_type;

   // Leap when divisible by 4, except centuries that are not a multiple of 400.
   function automatic logic is_leap(logic [R400_W-1:0] r400, logic [1:0] low2);
      return (low2 == 2'd0) && !(r400 inside {R400_W'(100), R400_W'(200), R400_W'(300)});
   endfunction

   function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
      logic [DAY_W-1:0] len;
      if (m == MONTH_W'(2)) begin
         len = leap ? DAY_W'(29) : DAY_W'(28);
      end else if (m inside {MONTH_W'(4), MONTH_W'(6), MONTH_W'(9), MONTH_W'(11)}) begin
         len = DAY_W'(30);
      end else begin
         len = DAY_W'(31);
      end
      return len;
   endfunction

   function automatic year_type to_year(logic [FYEAR_W-1:0] y);
      logic [YEAR_BITS+FYEAR_W-1:0] t;
      t = {{YEAR_BITS{1'b0}}, y};
      return t[YEAR_BITS-1:0];
   endfunction

   function automatic logic [FYEAR_W-1:0] from_year(year_type y);
      logic [YEAR_BITS+FYEAR_W-1:0] t;
      t = {{FYEAR_W{1'b0}}, y};
      return t[FYEAR_W-1:0];
   endfunction

endpackage

>>> hw/rtl/cdc_alu.sv
module cdc_alu (
   input  logic [cdc_pkg::ALU_W-1:0] a,
   input  logic [cdc_pkg::ALU_W-1:0] b,
   output cdc_pkg::alu_res_type      res
);

   // The extra top bit of the difference is the borrow, set when a < b.
   assign {res.borrow, res.diff} = {1'b0, a} - {1'b0, b};

endmodule

>>> hw/rtl/calendar_date_counter_unit.sv
// Set steps through mod, remainder and check; compare and advance run their own step,
// repeated per month boundary for advance; a bad month or unused op responds at once.
// The advance loop steps one month per cycle through the shared subtractor; set finds
// the new year modulo 400 with a reciprocal multiply and a subtract on the same unit.
// One item at a time: busy is high from accept until the result strobe.
// Synchronous reset loads 1 January 2000; results cannot be stalled.
module calendar_date_counter_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cdc_pkg::req_type req_data,
   output logic             rsp_valid,
   output cdc_pkg::rsp_type rsp_data
);

   cdc_pkg::state_type                     state_ff, state_in;
   logic [cdc_pkg::DAY_W-1:0]              cur_day_ff, cur_day_in;
   logic [cdc_pkg::MONTH_W-1:0]            cur_month_ff, cur_month_in;
   cdc_pkg::year_type                      cur_year_ff, cur_year_in;
   logic [cdc_pkg::R400_W-1:0]             r400_ff, r400_in;
   cdc_pkg::req_type                       req_ff, req_in;
   logic [cdc_pkg::R400_W-1:0]             rem_ff, rem_in;
   logic [cdc_pkg::QUO_W-1:0]              quo_ff, quo_in;
   logic [cdc_pkg::COUNT_W-1:0]            cnt_ff, cnt_in;
   cdc_pkg::status_type                    status_ff, status_in;
   logic                                   earlier_ff, earlier_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   cdc_pkg::rsp_type                       rsp_data_ff, rsp_data_in;

   logic [cdc_pkg::ALU_W-1:0]              alu_a, alu_b;
   cdc_pkg::alu_res_type                   alu_res;

   cdc_pkg::year_type                      new_year;
   logic                                   leap_cur, leap_new;
   logic [cdc_pkg::DAY_W-1:0]              len_cur, left, len_new;
   logic [cdc_pkg::DAY_W:0]                left_plus;
   logic [cdc_pkg::FYEAR_W-1:0]            set_year;
   logic [cdc_pkg::FYEAR_W-5:0]            year_div16;
   logic [cdc_pkg::PROD_W-1:0]             quo_prod;

   cdc_alu u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .res (alu_res)
   );

   assign new_year   = cdc_pkg::to_year(req_ff.year_in);
   assign leap_cur   = cdc_pkg::is_leap(r400_ff, cur_year_ff[1:0]);
   assign leap_new   = cdc_pkg::is_leap(rem_ff, new_year[1:0]);
   assign len_cur    = cdc_pkg::month_len(cur_month_ff, leap_cur);
   assign len_new    = cdc_pkg::month_len(req_ff.month_in, leap_new);
   assign left       = (cur_day_ff < len_cur) ? (len_cur - cur_day_ff) : '0;
   assign left_plus  = {1'b0, left} + (cdc_pkg::DAY_W+1)'(1);
   assign set_year   = cdc_pkg::from_year(new_year);
   assign year_div16 = set_year[cdc_pkg::FYEAR_W-1:4];
   assign quo_prod   = cdc_pkg::PROD_W'(year_div16) * cdc_pkg::PROD_W'(cdc_pkg::RECIP_25);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdc_pkg::S_IDLE;
         cur_day_ff   <= cdc_pkg::DAY_W'(1);
         cur_month_ff <= cdc_pkg::MONTH_W'(1);
         cur_year_ff  <= cdc_pkg::RESET_YEAR;
         r400_ff      <= cdc_pkg::RESET_R400;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
         r400_ff      <= r400_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      status_ff   <= status_in;
      earlier_ff  <= earlier_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;
      r400_in      = r400_ff;
      req_in       = req_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      status_in    = status_ff;
      earlier_in   = earlier_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      alu_a        = '0;
      alu_b        = '0;

      case (state_ff)
         cdc_pkg::S_IDLE: begin
            if (start) begin
               req_in     = req_data;
               status_in  = cdc_pkg::STAT_OK;
               earlier_in = 1'b0;
               rem_in     = '0;
               cnt_in     = req_data.day_count;
               case (req_data.op)
                  cdc_pkg::OP_SET: begin
                     if (req_data.month_in >= cdc_pkg::MONTH_W'(1) &&
                         req_data.month_in <= cdc_pkg::LAST_MONTH) begin
                        state_in = cdc_pkg::S_SET_MOD;
                     end else begin
                        status_in = cdc_pkg::STAT_BAD_MONTH;
                        state_in  = cdc_pkg::S_RESPOND;
                     end
                  end
                  cdc_pkg::OP_ADVANCE: state_in = cdc_pkg::S_ADVANCE;
                  cdc_pkg::OP_COMPARE: state_in = cdc_pkg::S_COMPARE;
                  default:             state_in = cdc_pkg::S_RESPOND;
               endcase
            end
         end

         // The year over 400 is the year over 16 with a shift, then over 25 with
         // a reciprocal multiply.
         cdc_pkg::S_SET_MOD: begin
            quo_in   = quo_prod[cdc_pkg::RECIP_SHIFT +: cdc_pkg::QUO_W];
            state_in = cdc_pkg::S_SET_REM;
         end

         cdc_pkg::S_SET_REM: begin
            alu_a    = cdc_pkg::ALU_W'(set_year);
            alu_b    = cdc_pkg::ALU_W'(quo_ff) * cdc_pkg::ALU_W'(cdc_pkg::YEAR_PERIOD);
            rem_in   = alu_res.diff[cdc_pkg::R400_W-1:0];
            state_in = cdc_pkg::S_SET_CHK;
         end

         cdc_pkg::S_SET_CHK: begin
            if (req_ff.day_in == '0 || req_ff.day_in > len_new) begin
               status_in = cdc_pkg::STAT_BAD_DAY;
            end else begin
               cur_day_in   = req_ff.day_in;
               cur_month_in = req_ff.month_in;
               cur_year_in  = new_year;
               r400_in      = rem_ff;
            end
            state_in = cdc_pkg::S_RESPOND;
         end

         // One month per cycle: either the count lands inside this month,
         // or the rest of the month is consumed and the date rolls over.
         cdc_pkg::S_ADVANCE: begin
            alu_a = cdc_pkg::ALU_W'(cnt_ff);
            alu_b = cdc_pkg::ALU_W'(left_plus);
            if (alu_res.borrow) begin
               cur_day_in = cur_day_ff + cnt_ff[cdc_pkg::DAY_W-1:0];
               state_in   = cdc_pkg::S_RESPOND;
            end else begin
               cnt_in     = alu_res.diff[cdc_pkg::COUNT_W-1:0];
               cur_day_in = cdc_pkg::DAY_W'(1);
               if (cur_month_ff >= cdc_pkg::LAST_MONTH) begin
                  cur_month_in = cdc_pkg::MONTH_W'(1);
                  cur_year_in  = cur_year_ff + cdc_pkg::YEAR_BITS'(1);
                  // A wrap to year zero restarts the 400-year cycle as well.
                  if (cur_year_ff == '1 ||
                      r400_ff == cdc_pkg::YEAR_PERIOD - cdc_pkg::R400_W'(1)) begin
                     r400_in = '0;
                  end else begin
                     r400_in = r400_ff + cdc_pkg::R400_W'(1);
                  end
               end else begin
                  cur_month_in = cur_month_ff + cdc_pkg::MONTH_W'(1);
               end
            end
         end

         // Year, month and day concatenated compare lexicographically.
         cdc_pkg::S_COMPARE: begin
            alu_a      = {cur_year_ff, cur_month_ff, cur_day_ff};
            alu_b      = {new_year, req_ff.month_in, req_ff.day_in};
            earlier_in = alu_res.borrow;
            state_in   = cdc_pkg::S_RESPOND;
         end

         cdc_pkg::S_RESPOND: begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.day_out    = cur_day_ff;
            rsp_data_in.month_out  = cur_month_ff;
            rsp_data_in.year_out   = cdc_pkg::from_year(cur_year_ff);
            rsp_data_in.status     = status_ff;
            rsp_data_in.is_earlier = earlier_ff;
            state_in               = cdc_pkg::S_IDLE;
         end

         default: state_in = cdc_pkg::S_IDLE;
      endcase
   end

   assign busy      = (state_ff != cdc_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_after_respond: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == cdc_pkg::S_RESPOND))
      else $error("result beat without a respond step");

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not make the block busy");

   a_month_valid: assert property (@(posedge clock) disable iff (reset)
      cur_month_ff >= cdc_pkg::MONTH_W'(1) && cur_month_ff <= cdc_pkg::LAST_MONTH)
      else $error("stored month out of range");

   a_day_valid: assert property (@(posedge clock) disable iff (reset)
      cur_day_ff >= cdc_pkg::DAY_W'(1) && cur_day_ff <= len_cur)
      else $error("stored day past the end of its month");

endmodule

>>> tb/sv/calendar_date_checker.sv
`timescale 1ns / 100ps

module calendar_date_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  cdc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  cdc_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending,
   output int               checked
);

   logic [cdc_pkg::DAY_W-1:0]   cal_day;
   logic [cdc_pkg::MONTH_W-1:0] cal_month;
   logic [cdc_pkg::FYEAR_W-1:0] cal_year;
   cdc_pkg::rsp_type            pending_dates[$];
   cdc_pkg::rsp_type            due;

   initial begin
      fail_count = 0;
      pending    = 0;
      checked    = 0;
   end

   function automatic bit leap_year(logic [cdc_pkg::FYEAR_W-1:0] y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   // Month codes outside 1..12 count as 31 days; callers never pass one, as set checks the month first.
   function automatic int unsigned days_of_month(logic [cdc_pkg::MONTH_W-1:0] m,
                                                 logic [cdc_pkg::FYEAR_W-1:0] y);
      int unsigned len;
      case (m)
         4'd2: begin
            len = leap_year(y) ? 29 : 28;
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 30;
         end
         default: begin
            len = 31;
         end
      endcase
      return len;
   endfunction

   task automatic roll_forward(int unsigned count);
      int unsigned len;
      int unsigned left;
      while (count > 0) begin
         len  = days_of_month(cal_month, cal_year);
         left = (cal_day < len) ? len - cal_day : 0;
         if (count <= left) begin
            cal_day = cal_day + cdc_pkg::DAY_W'(count);
            count   = 0;
         end else begin
            count   = count - (left + 1);
            cal_day = cdc_pkg::DAY_W'(1);
            if (cal_month >= cdc_pkg::LAST_MONTH) begin
               cal_month = cdc_pkg::MONTH_W'(1);
               cal_year  = cal_year + 1'b1;
            end else begin
               cal_month = cal_month + 1'b1;
            end
         end
      end
   endtask

   task automatic predict_date(cdc_pkg::req_type r);
      cdc_pkg::rsp_type    want;
      cdc_pkg::status_type st;
      logic                earlier;
      st      = cdc_pkg::STAT_OK;
      earlier = 1'b0;
      case (r.op)
         cdc_pkg::OP_SET: begin
            if (r.month_in < 1 || r.month_in > cdc_pkg::LAST_MONTH) begin
               st = cdc_pkg::STAT_BAD_MONTH;
            end else if (r.day_in == 0 ||
                         r.day_in > days_of_month(r.month_in, r.year_in)) begin
               st = cdc_pkg::STAT_BAD_DAY;
            end else begin
               cal_day   = r.day_in;
               cal_month = r.month_in;
               cal_year  = r.year_in;
            end
         end
         cdc_pkg::OP_ADVANCE: begin
            roll_forward(r.day_count);
         end
         cdc_pkg::OP_COMPARE: begin
            // Year, then month, then day: one wide unsigned compare does the same.
            earlier = {cal_year, cal_month, cal_day} < {r.year_in, r.month_in, r.day_in};
         end
         default: begin
         end
      endcase
      want.day_out    = cal_day;
      want.month_out  = cal_month;
      want.year_out   = cal_year;
      want.status     = st;
      want.is_earlier = earlier;
      pending_dates.push_back(want);
   endtask

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cal_day   = cdc_pkg::DAY_W'(1);
         cal_month = cdc_pkg::MONTH_W'(1);
         cal_year  = cdc_pkg::FYEAR_W'(2000);
         pending_dates.delete();
      end else begin
         // Retire the result beat first, so a request taken on the same edge queues behind it.
         if (rsp_valid) begin
            if (pending_dates.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with nothing expected, expected none, got %0d/%0d/%0d",
                        $time, rsp_data.day_out, rsp_data.month_out, rsp_data.year_out);
            end else begin
               due = pending_dates.pop_front();
               checked++;
               check_field("day", due.day_out, rsp_data.day_out);
               check_field("month", due.month_out, rsp_data.month_out);
               check_field("year", due.year_out, rsp_data.year_out);
               check_field("status", due.status, rsp_data.status);
               check_field("is_earlier", due.is_earlier, rsp_data.is_earlier);
            end
         end
         if (start && !busy) begin
            predict_date(req_data);
         end
      end
      pending = pending_dates.size();
   end

endmodule

>>> tb/sv/calendar_date_counter_unit_tb.sv
`timescale 1ns / 100ps

module calendar_date_counter_unit_tb;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   cdc_pkg::req_type req_data;
   logic             rsp_valid;
   cdc_pkg::rsp_type rsp_data;

   int fail_count;
   int pending;
   int checked;
   int op_tally[4];
   int last_year;
   int last_month;
   bit quiet;

   calendar_date_counter_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   calendar_date_checker date_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #500_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Called just after a falling edge. Start stays high afterwards, so back-to-back
   // beats need no extra toggle; busy only moves on rising edges.
   task automatic send_op(cdc_pkg::op_type op, int d, int m, int y, int cnt);
      cdc_pkg::req_type r;
      r.op        = op;
      r.day_in    = cdc_pkg::DAY_W'(d);
      r.month_in  = cdc_pkg::MONTH_W'(m);
      r.year_in   = cdc_pkg::FYEAR_W'(y);
      r.day_count = cdc_pkg::COUNT_W'(cnt);
      start       = 1'b1;
      req_data    = r;
      while (busy) begin
         @(negedge clock);
      end
      @(negedge clock);
      op_tally[op]++;
      if (op == cdc_pkg::OP_SET) begin
         last_year  = r.year_in;
         last_month = r.month_in;
      end
   endtask

   task automatic idle_gap(int cycles);
      start = 1'b0;
      repeat (cycles) begin
         @(negedge clock);
      end
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(99) < 30) begin
         idle_gap($urandom_range(1, 24));
      end
   endtask

   task automatic drain();
      start = 1'b0;
      while (pending != 0) begin
         @(negedge clock);
      end
   endtask

   function automatic int pick_year();
      int sel;
      sel = $urandom_range(9);
      if (sel < 4) begin
         return $urandom_range(65535);
      end else if (sel < 8) begin
         return $urandom_range(1580, 2420);
      end
      return $urandom_range(65500, 65535);
   endfunction

   task automatic random_item();
      int pick;
      int sel;
      int d;
      int m;
      int y;
      int cnt;
      pick = $urandom_range(99);
      sel  = $urandom_range(9);
      if (pick < 30) begin
         y = pick_year();
         if (sel < 8) begin
            m = $urandom_range(1, 12);
            d = ($urandom_range(3) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
         end else if (sel == 8) begin
            m = $urandom_range(1) ? 0 : $urandom_range(13, 15);
            d = $urandom_range(31);
         end else begin
            m = $urandom_range(1, 12);
            d = $urandom_range(1) ? 0 : $urandom_range(29, 31);
         end
         send_op(cdc_pkg::OP_SET, d, m, y, $urandom_range(65535));
      end else if (pick < 70) begin
         if (sel < 5) begin
            cnt = 1;
         end else if (sel < 7) begin
            cnt = $urandom_range(40);
         end else if (sel < 9) begin
            cnt = $urandom_range(1000);
         end else begin
            cnt = $urandom_range(65535);
         end
         send_op(cdc_pkg::OP_ADVANCE, $urandom_range(31), $urandom_range(15),
                 $urandom_range(65535), cnt);
      end else if (pick < 95) begin
         // Compare mostly against the year, and often the month, of the last set request to reach the tie-breaks.
         sel = $urandom_range(3);
         d   = $urandom_range(31);
         if (sel < 2) begin
            send_op(cdc_pkg::OP_COMPARE, d, last_month, last_year, $urandom_range(65535));
         end else if (sel == 2) begin
            send_op(cdc_pkg::OP_COMPARE, d, $urandom_range(15), last_year,
                    $urandom_range(65535));
         end else begin
            send_op(cdc_pkg::OP_COMPARE, d, $urandom_range(15), pick_year(),
                    $urandom_range(65535));
         end
      end else begin
         send_op(cdc_pkg::OP_NONE, $urandom_range(31), $urandom_range(15),
                 $urandom_range(65535), $urandom_range(65535));
      end
   endtask

   initial begin
      start      = 1'b0;
      req_data   = '0;
      reset      = 1'b1;
      quiet      = 1'b0;
      last_year  = 2000;
      last_month = 1;
      repeat (7) begin
         @(posedge clock);
      end
      @(negedge clock);
      reset = 1'b0;

      send_op(cdc_pkg::OP_COMPARE, 1, 1, 2000, 0);
      send_op(cdc_pkg::OP_COMPARE, 2, 1, 2000, 65535);
      send_op(cdc_pkg::OP_SET, 29, 2, 2000, 0);
      maybe_gap();
      send_op(cdc_pkg::OP_SET, 29, 2, 1900, 0);
      send_op(cdc_pkg::OP_SET, 29, 2, 2100, 0);
      send_op(cdc_pkg::OP_SET, 29, 2, 2023, 0);
      send_op(cdc_pkg::OP_SET, 29, 2, 2024, 0);
      maybe_gap();
      send_op(cdc_pkg::OP_SET, 1, 0, 2024, 0);
      send_op(cdc_pkg::OP_SET, 31, 15, 65535, 0);
      send_op(cdc_pkg::OP_SET, 0, 5, 1999, 0);
      send_op(cdc_pkg::OP_SET, 31, 4, 1999, 0);
      send_op(cdc_pkg::OP_SET, 28, 2, 1900, 0);
      send_op(cdc_pkg::OP_ADVANCE, 0, 0, 0, 1);
      send_op(cdc_pkg::OP_SET, 28, 2, 2000, 0);
      send_op(cdc_pkg::OP_ADVANCE, 31, 15, 65535, 1);
      send_op(cdc_pkg::OP_ADVANCE, 31, 15, 65535, 0);
      send_op(cdc_pkg::OP_NONE, 31, 15, 65535, 65535);
      maybe_gap();
      send_op(cdc_pkg::OP_SET, 31, 12, 65535, 0);
      send_op(cdc_pkg::OP_ADVANCE, 0, 0, 0, 1);
      send_op(cdc_pkg::OP_COMPARE, 31, 15, 65535, 0);
      send_op(cdc_pkg::OP_COMPARE, 0, 0, 0, 0);
      send_op(cdc_pkg::OP_SET, 29, 2, 0, 0);
      send_op(cdc_pkg::OP_ADVANCE, 0, 0, 0, 65535);
      send_op(cdc_pkg::OP_SET, 15, 6, 2024, 65535);
      send_op(cdc_pkg::OP_COMPARE, 16, 6, 2024, 0);
      send_op(cdc_pkg::OP_COMPARE, 15, 6, 2024, 0);
      send_op(cdc_pkg::OP_COMPARE, 14, 7, 2024, 0);
      drain();

      for (int i = 0; i < 1850; i++) begin
         quiet = (i >= 800 && i < 1100);
         if (i == 500) begin
            drain();
         end
         maybe_gap();
         random_item();
      end

      drain();
      repeat (40) begin
         @(negedge clock);
      end

      $display("Covered %0d set, %0d advance, %0d compare and %0d unused-op requests.",
               op_tally[cdc_pkg::OP_SET], op_tally[cdc_pkg::OP_ADVANCE],
               op_tally[cdc_pkg::OP_COMPARE], op_tally[cdc_pkg::OP_NONE]);
      $display("%0d result beats checked, %0d mismatches found.", checked, fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/cdc_pkg.sv
hw/rtl/cdc_alu.sv
hw/rtl/calendar_date_counter_unit.sv
tb/sv/calendar_date_checker.sv
tb/sv/calendar_date_counter_unit_tb.sv
